### hw/rtl/b91pe_pkg.sv
// Shared constants for the base-91 position encoder.
// Reciprocals for the constant divisions and the base-91 place weights.
// No dependencies.
`default_nettype none

package b91pe_pkg;

  // Shift used by every reciprocal multiply
  localparam int unsigned RecipShift = 32;

  // Degrees/minutes split
  localparam logic [19:0] DegDiv   = 20'd1000000;
  localparam logic [12:0] DegRecip = 13'((64'd1 << RecipShift) / 64'd1000000);
  localparam logic [13:0] DegScale = 14'd10000;
  localparam logic [5:0]  MinDiv   = 6'd60;
  localparam logic [26:0] MinRecip = 27'((64'd1 << RecipShift) / 64'd60);

  // Offset references and limits
  localparam logic signed [23:0] LatRef = 24'sd900000;
  localparam logic signed [23:0] LonRef = 24'sd1800000;
  localparam logic signed [23:0] LatMax = 24'sd1800000;
  localparam logic signed [23:0] LonMax = 24'sd3600000;

  // Scale factors over 10000, split into whole and fraction parts
  localparam int unsigned LatScale   = 380926;
  localparam int unsigned LonScale   = 190463;
  localparam int unsigned ScaleDivI  = 10000;
  localparam logic [13:0] ScaleDiv   = 14'(ScaleDivI);
  localparam logic [5:0]  LatWhole   = 6'(LatScale / ScaleDivI);
  localparam logic [9:0]  LatFrac    = 10'(LatScale % ScaleDivI);
  localparam logic [5:0]  LonWhole   = 6'(LonScale / ScaleDivI);
  localparam logic [9:0]  LonFrac    = 10'(LonScale % ScaleDivI);
  localparam logic [18:0] ScaleRecip = 19'((64'd1 << RecipShift) / 64'd10000);

  // Base-91 place weights and their reciprocals
  localparam logic [19:0] Weight0 = 20'd753571;
  localparam logic [13:0] Weight1 = 14'd8281;
  localparam logic [6:0]  Weight2 = 7'd91;
  localparam logic [12:0] Recip0  = 13'((64'd1 << RecipShift) / 64'd753571);
  localparam logic [18:0] Recip1  = 19'((64'd1 << RecipShift) / 64'd8281);
  localparam logic [25:0] Recip2  = 26'((64'd1 << RecipShift) / 64'd91);

  // ASCII '!'
  localparam logic [6:0] CharBase = 7'd33;

endpackage

`default_nettype wire

### hw/rtl/b91pe_deg.sv
// Degrees-and-minutes to decimal degrees, offset from the reference and clamp.
// Five register stages with per-stage valid. Uses b91pe_pkg.
`default_nettype none

module b91pe_deg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        func_i,
  input  logic [27:0] coord_i,
  input  logic        sow_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        func_o,
  output logic [21:0] off_o,
  output logic        clamped_o
);

  localparam int Stages = 5;

  logic [Stages-1:0] v_q;
  logic [Stages:0]   rdy;

  always_comb begin
    rdy[Stages] = !stall_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign stall_o = !rdy[0];
  assign valid_o = v_q[Stages-1];

  // stage 0: estimate of whole degrees
  logic [40:0] p0;
  logic [27:0] s0_coord_q;
  logic [8:0]  s0_q_q;
  logic        s0_func_q, s0_sow_q;
  assign p0 = 41'(coord_i) * 41'(b91pe_pkg::DegRecip);

  // stage 1: correct degrees, minute part
  logic [27:0] r1;
  logic        ge1;
  logic [8:0]  s1_q_q;
  logic [19:0] s1_m_q;
  logic        s1_func_q, s1_sow_q;
  assign r1  = s0_coord_q - 28'(28'(s0_q_q) * 28'(b91pe_pkg::DegDiv));
  assign ge1 = r1 >= 28'(b91pe_pkg::DegDiv);

  // stage 2: minutes / 60 estimate, degrees times 10000
  logic [46:0] p2;
  logic [19:0] s2_m_q;
  logic [14:0] s2_est_q;
  logic [21:0] s2_w_q;
  logic        s2_func_q, s2_sow_q;
  assign p2 = 47'(s1_m_q) * 47'(b91pe_pkg::MinRecip);

  // stage 3: corrected decimal value
  logic [19:0] r3;
  logic        ge3;
  logic [21:0] s3_dec_q;
  logic        s3_func_q, s3_sow_q;
  assign r3  = s2_m_q - 20'(20'(s2_est_q) * 20'(b91pe_pkg::MinDiv));
  assign ge3 = r3 >= 20'(b91pe_pkg::MinDiv);

  // stage 4: offset and clamp
  logic signed [23:0] base, lim, off;
  logic               add_dec;
  logic [21:0]        off_d;
  logic               clip_d;
  always_comb begin
    base    = s3_func_q ? b91pe_pkg::LonRef : b91pe_pkg::LatRef;
    lim     = s3_func_q ? b91pe_pkg::LonMax : b91pe_pkg::LatMax;
    add_dec = s3_func_q ? !s3_sow_q : s3_sow_q;
    off     = add_dec ? base + $signed({2'b00, s3_dec_q})
                      : base - $signed({2'b00, s3_dec_q});
    clip_d  = 1'b0;
    off_d   = off[21:0];
    if (off < 0) begin
      off_d  = '0;
      clip_d = 1'b1;
    end else if (off > lim) begin
      off_d  = lim[21:0];
      clip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_coord_q <= coord_i;
      s0_q_q     <= p0[40:32];
      s0_func_q  <= func_i;
      s0_sow_q   <= sow_i;
    end
    if (rdy[1]) begin
      s1_q_q    <= s0_q_q + 9'(ge1);
      s1_m_q    <= ge1 ? 20'(r1 - 28'(b91pe_pkg::DegDiv)) : r1[19:0];
      s1_func_q <= s0_func_q;
      s1_sow_q  <= s0_sow_q;
    end
    if (rdy[2]) begin
      s2_m_q    <= s1_m_q;
      s2_est_q  <= p2[46:32];
      s2_w_q    <= 22'(s1_q_q) * 22'(b91pe_pkg::DegScale);
      s2_func_q <= s1_func_q;
      s2_sow_q  <= s1_sow_q;
    end
    if (rdy[3]) begin
      s3_dec_q  <= s2_w_q + 22'(s2_est_q) + 22'(ge3);
      s3_func_q <= s2_func_q;
      s3_sow_q  <= s2_sow_q;
    end
    if (rdy[4]) begin
      off_o     <= off_d;
      clamped_o <= clip_d;
      func_o    <= s3_func_q;
    end
  end

  // latitude offsets never leave 0..1800000 after the clamp
  a_lat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !func_o) |-> (off_o <= 22'd1800000))
    else $error("latitude offset out of range");

  // minute remainder after correction stays below one degree
  a_min_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (s1_m_q < b91pe_pkg::DegDiv))
    else $error("minute part not reduced");

endmodule

`default_nettype wire

### hw/rtl/b91pe_scale.sv
// Scales the clamped offset by 380926 or 190463 over 10000, floor.
// Three register stages with per-stage valid. Uses b91pe_pkg.
`default_nettype none

module b91pe_scale (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        func_i,
  input  logic [21:0] off_i,
  input  logic        clamped_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [26:0] val_o,
  output logic        clamped_o
);

  localparam int Stages = 3;

  logic [Stages-1:0] v_q;
  logic [Stages:0]   rdy;

  always_comb begin
    rdy[Stages] = !stall_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign stall_o = !rdy[0];
  assign valid_o = v_q[Stages-1];

  // stage 0: whole and fractional products
  logic [9:0]  k_frac;
  logic [5:0]  k_whole;
  logic [30:0] s0_x_q;
  logic [26:0] s0_y_q;
  logic        s0_clip_q;
  assign k_frac  = func_i ? b91pe_pkg::LonFrac : b91pe_pkg::LatFrac;
  assign k_whole = func_i ? b91pe_pkg::LonWhole : b91pe_pkg::LatWhole;

  // stage 1: fraction / 10000 estimate
  logic [49:0] p1;
  logic [30:0] s1_x_q;
  logic [26:0] s1_y_q;
  logic [17:0] s1_est_q;
  logic        s1_clip_q;
  assign p1 = 50'(s0_x_q) * 50'(b91pe_pkg::ScaleRecip);

  // stage 2: correct and sum
  logic [30:0] r2;
  logic        ge2;
  assign r2  = s1_x_q - 31'(31'(s1_est_q) * 31'(b91pe_pkg::ScaleDiv));
  assign ge2 = r2 >= 31'(b91pe_pkg::ScaleDiv);

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_x_q    <= 31'(off_i) * 31'(k_frac);
      s0_y_q    <= 27'(off_i) * 27'(k_whole);
      s0_clip_q <= clamped_i;
    end
    if (rdy[1]) begin
      s1_x_q    <= s0_x_q;
      s1_y_q    <= s0_y_q;
      s1_est_q  <= p1[49:32];
      s1_clip_q <= s0_clip_q;
    end
    if (rdy[2]) begin
      val_o     <= s1_y_q + 27'(s1_est_q) + 27'(ge2);
      clamped_o <= s1_clip_q;
    end
  end

  // scaled value always fits four base-91 digits
  a_val_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (val_o <= 27'd68566680))
    else $error("scaled value exceeds four digits");

endmodule

`default_nettype wire

### hw/rtl/b91pe_digits.sv
// Splits the scaled value into four base-91 digits and adds '!'.
// Six register stages with per-stage valid. Uses b91pe_pkg.
`default_nettype none

module b91pe_digits (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [26:0] val_i,
  input  logic        clamped_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [6:0]  char0_o,
  output logic [6:0]  char1_o,
  output logic [6:0]  char2_o,
  output logic [6:0]  char3_o,
  output logic        clamped_o
);

  localparam int Stages = 6;

  logic [Stages-1:0] v_q;
  logic [Stages:0]   rdy;

  always_comb begin
    rdy[Stages] = !stall_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign stall_o = !rdy[0];
  assign valid_o = v_q[Stages-1];

  // stage 0: top digit estimate
  logic [39:0] p0;
  logic [26:0] s0_val_q;
  logic [6:0]  s0_e_q;
  logic        s0_clip_q;
  assign p0 = 40'(val_i) * 40'(b91pe_pkg::Recip0);

  // stage 1: top digit correct
  logic [26:0] r1;
  logic        ge1;
  logic [6:0]  s1_d0_q;
  logic [19:0] s1_rem_q;
  logic        s1_clip_q;
  assign r1  = s0_val_q - 27'(27'(s0_e_q) * 27'(b91pe_pkg::Weight0));
  assign ge1 = r1 >= 27'(b91pe_pkg::Weight0);

  // stage 2: second digit estimate
  logic [38:0] p2;
  logic [6:0]  s2_d0_q, s2_e_q;
  logic [19:0] s2_rem_q;
  logic        s2_clip_q;
  assign p2 = 39'(s1_rem_q) * 39'(b91pe_pkg::Recip1);

  // stage 3: second digit correct
  logic [19:0] r3;
  logic        ge3;
  logic [6:0]  s3_d0_q, s3_d1_q;
  logic [13:0] s3_rem_q;
  logic        s3_clip_q;
  assign r3  = s2_rem_q - 20'(20'(s2_e_q) * 20'(b91pe_pkg::Weight1));
  assign ge3 = r3 >= 20'(b91pe_pkg::Weight1);

  // stage 4: third digit estimate
  logic [39:0] p4;
  logic [6:0]  s4_d0_q, s4_d1_q, s4_e_q;
  logic [13:0] s4_rem_q;
  logic        s4_clip_q;
  assign p4 = 40'(s3_rem_q) * 40'(b91pe_pkg::Recip2);

  // stage 5: third digit correct, last digit is the remainder
  logic [13:0] r5;
  logic        ge5;
  logic [6:0]  d3;
  assign r5  = s4_rem_q - 14'(14'(s4_e_q) * 14'(b91pe_pkg::Weight2));
  assign ge5 = r5 >= 14'(b91pe_pkg::Weight2);
  assign d3  = ge5 ? 7'(r5 - 14'(b91pe_pkg::Weight2)) : r5[6:0];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_val_q  <= val_i;
      s0_e_q    <= p0[38:32];
      s0_clip_q <= clamped_i;
    end
    if (rdy[1]) begin
      s1_d0_q   <= s0_e_q + 7'(ge1);
      s1_rem_q  <= ge1 ? 20'(r1 - 27'(b91pe_pkg::Weight0)) : r1[19:0];
      s1_clip_q <= s0_clip_q;
    end
    if (rdy[2]) begin
      s2_d0_q   <= s1_d0_q;
      s2_e_q    <= p2[38:32];
      s2_rem_q  <= s1_rem_q;
      s2_clip_q <= s1_clip_q;
    end
    if (rdy[3]) begin
      s3_d0_q   <= s2_d0_q;
      s3_d1_q   <= s2_e_q + 7'(ge3);
      s3_rem_q  <= ge3 ? 14'(r3 - 20'(b91pe_pkg::Weight1)) : r3[13:0];
      s3_clip_q <= s2_clip_q;
    end
    if (rdy[4]) begin
      s4_d0_q   <= s3_d0_q;
      s4_d1_q   <= s3_d1_q;
      s4_e_q    <= p4[38:32];
      s4_rem_q  <= s3_rem_q;
      s4_clip_q <= s3_clip_q;
    end
    if (rdy[5]) begin
      char0_o   <= s4_d0_q + b91pe_pkg::CharBase;
      char1_o   <= s4_d1_q + b91pe_pkg::CharBase;
      char2_o   <= s4_e_q + 7'(ge5) + b91pe_pkg::CharBase;
      char3_o   <= d3 + b91pe_pkg::CharBase;
      clamped_o <= s4_clip_q;
    end
  end

  // remainders after correction are below their place weight
  a_rem1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (s1_rem_q < b91pe_pkg::Weight0))
    else $error("first remainder not reduced");

  a_rem3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (s3_rem_q < b91pe_pkg::Weight1))
    else $error("second remainder not reduced");

endmodule

`default_nettype wire

### hw/rtl/base91_position_encoder_unit.sv
// Pipeline: 14 register stages (5 conversion, 3 scaling, 6 digit); an item
// accepted at the input passes through them in order, and out_valid_o is the
// valid bit of the last digit stage. Throughput: one item per cycle while
// out_stall_i is low; every stage holds one item and an empty stage fills
// even while stages ahead are held; a stalled output holds only full stages.
// Reset: rst_ni clears all stage valid bits; payload registers are not reset.
// Top level: b91pe_deg -> b91pe_scale -> b91pe_digits. Uses b91pe_pkg.
`default_nettype none

module base91_position_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [27:0] coord_i,
  input  logic        south_or_west_i,
  // result item
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  code_char_0_o,
  output logic [6:0]  code_char_1_o,
  output logic [6:0]  code_char_2_o,
  output logic [6:0]  code_char_3_o,
  output logic        clamped_o
);

  // conversion -> scaling handshake and payload
  logic        deg_valid, deg_stall;
  logic        deg_func, deg_clip;
  logic [21:0] deg_off;

  // scaling -> digit split handshake and payload
  logic        scl_valid, scl_stall;
  logic [26:0] scl_val;
  logic        scl_clip;

  // ddmm.mmmm to decimal degrees, offset from 90 N or 180 W, clamp
  b91pe_deg u_deg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .stall_o   (in_stall_o),
    .func_i    (func_i),
    .coord_i   (coord_i),
    .sow_i     (south_or_west_i),
    .valid_o   (deg_valid),
    .stall_i   (deg_stall),
    .func_o    (deg_func),
    .off_o     (deg_off),
    .clamped_o (deg_clip)
  );

  // offset * scale / 10000, exact floor
  b91pe_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (deg_valid),
    .stall_o   (deg_stall),
    .func_i    (deg_func),
    .off_i     (deg_off),
    .clamped_i (deg_clip),
    .valid_o   (scl_valid),
    .stall_i   (scl_stall),
    .val_o     (scl_val),
    .clamped_o (scl_clip)
  );

  // four base-91 digits; its last stage is the output register
  b91pe_digits u_digits (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (scl_valid),
    .stall_o   (scl_stall),
    .val_i     (scl_val),
    .clamped_i (scl_clip),
    .valid_o   (out_valid_o),
    .stall_i   (out_stall_i),
    .char0_o   (code_char_0_o),
    .char1_o   (code_char_1_o),
    .char2_o   (code_char_2_o),
    .char3_o   (code_char_3_o),
    .clamped_o (clamped_o)
  );

  // the input can only be held back by a stalled output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output free");

  // every character is printable base-91
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (code_char_0_o >= 7'd33 && code_char_0_o <= 7'd123 &&
                     code_char_1_o >= 7'd33 && code_char_1_o <= 7'd123 &&
                     code_char_2_o >= 7'd33 && code_char_2_o <= 7'd123 &&
                     code_char_3_o >= 7'd33 && code_char_3_o <= 7'd123))
    else $error("character out of base-91 range");

endmodule

`default_nettype wire

### bench/base91_position_encoder_unit_tb.sv
// Testbench for base91_position_encoder_unit: latitude/longitude items in, four base-91
// characters plus a clamp flag out, checked in order against an in-bench integer predictor.
// Depends only on the DUT (base91_position_encoder_unit) and its package b91pe_pkg.

module base91_position_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // func_i codes
  localparam logic FuncLat = 1'b0;
  localparam logic FuncLon = 1'b1;

  // Conversion constants, all in units of 1e-4 degree unless noted
  localparam longint DegSplit   = 1000000;  // ddmm.mmmm * 10000 -> whole-degree boundary
  localparam longint LatOrigin  = 900000;   // 90 N
  localparam longint LonOrigin  = 1800000;  // 180 W
  localparam longint LatSpan    = 1800000;
  localparam longint LonSpan    = 3600000;
  localparam longint LatFactor  = 380926;   // scaled by 1/10000
  localparam longint LonFactor  = 190463;
  localparam longint FactorDiv  = 10000;
  localparam longint AsciiBang  = 33;
  localparam longint PlaceWeight [4] = '{753571, 8281, 91, 1};

  localparam int RandPerPhase = 266;
  localparam int DrainCycles  = 30;   // wait after the last phase for stray results
  localparam int MaxReports   = 10;

  typedef struct {
    logic        func;
    logic [27:0] coord;
    logic        sow;
  } pos_item_t;

  typedef struct packed {
    logic [0:3][6:0] chars;
    logic            clamped;
  } code_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        func_i = 1'b0;
  logic [27:0] coord_i = '0;
  logic        south_or_west_i = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [6:0]  code_char_0_o, code_char_1_o, code_char_2_o, code_char_3_o;
  logic        clamped_o;

  base91_position_encoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .coord_i         (coord_i),
    .south_or_west_i (south_or_west_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .code_char_0_o   (code_char_0_o),
    .code_char_1_o   (code_char_1_o),
    .code_char_2_o   (code_char_2_o),
    .code_char_3_o   (code_char_3_o),
    .clamped_o       (clamped_o)
  );

  always #5 clk_i = ~clk_i;

  pos_item_t pending_items [$];   // items not yet offered to the DUT
  code_t     code_queue [$];      // predicted results, oldest first

  int  send_idle_pct = 0;         // chance per cycle that the driver holds off
  int  stall_pct = 0;             // chance per cycle that the sink stalls
  bit  in_taken = 1'b0;           // item on the inputs was accepted at the last edge
  int  items_sent = 0;
  int  codes_checked = 0;
  int  clamps_seen = 0;
  int  mismatches = 0;

  // Predictor: degrees-minutes to decimal degrees (floor), offset from the
  // origin, clamp, scale with floor, then split into four base-91 digits.
  function automatic code_t encode_position(pos_item_t it);
    longint minutes_part, decimal, offset, limit, factor, scaled, digit;
    code_t  res;
    minutes_part = longint'({36'd0, it.coord}) % DegSplit;
    decimal = (longint'({36'd0, it.coord}) - minutes_part) / 100 + minutes_part / 60;
    if (it.func == FuncLon) begin
      offset = it.sow ? LonOrigin - decimal : LonOrigin + decimal;
      limit  = LonSpan;
      factor = LonFactor;
    end else begin
      offset = it.sow ? LatOrigin + decimal : LatOrigin - decimal;
      limit  = LatSpan;
      factor = LatFactor;
    end
    res.clamped = 1'b0;
    if (offset < 0) begin
      offset = 0;
      res.clamped = 1'b1;
    end else if (offset > limit) begin
      offset = limit;
      res.clamped = 1'b1;
    end
    scaled = factor * offset / FactorDiv;
    for (int i = 0; i < 4; i++) begin
      digit  = scaled / PlaceWeight[i];
      scaled = scaled % PlaceWeight[i];
      res.chars[i] = 7'(digit + AsciiBang);
    end
    return res;
  endfunction

  function automatic pos_item_t make_item(logic func, logic [27:0] coord, logic sow);
    pos_item_t it;
    it.func  = func;
    it.coord = coord;
    it.sow   = sow;
    return it;
  endfunction

  // Random item: mostly real positions, plus border cases, bad minutes and raw noise
  function automatic pos_item_t random_item();
    int          pick;
    logic        func;
    int unsigned deg_top, degs, mins;
    pick = $urandom_range(99);
    func = 1'($urandom_range(1));
    deg_top = (func == FuncLon) ? 180 : 90;
    mins = $urandom_range(599999);
    if (pick < 65) begin
      degs = $urandom_range(deg_top);
    end else if (pick < 80) begin
      // hug the pole / antimeridian, both sides of it
      degs = deg_top - 1 + $urandom_range(2);
      if ($urandom_range(3) == 0) mins = $urandom_range(119);
    end else if (pick < 90) begin
      // minute field of 60 or more
      degs = $urandom_range(deg_top);
      mins = $urandom_range(999999, 600000);
    end else begin
      return make_item(func, 28'($urandom), 1'($urandom_range(1)));
    end
    return make_item(func, 28'(degs * 1000000 + mins), 1'($urandom_range(1)));
  endfunction

  task automatic note_mismatch(string what, code_t want, code_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%s at %0t: exp %0d %0d %0d %0d clamp %0b, got %0d %0d %0d %0d clamp %0b",
               what, $realtime, want.chars[0], want.chars[1], want.chars[2], want.chars[3],
               want.clamped, got.chars[0], got.chars[1], got.chars[2], got.chars[3],
               got.clamped);
    end
  endtask

  // Sample both handshakes at the rising edge. Output check runs before the
  // input push; input to output is registered, so the order does not matter here.
  always @(posedge clk_i) begin
    code_t want, got;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.chars   = {code_char_0_o, code_char_1_o, code_char_2_o, code_char_3_o};
        got.clamped = clamped_o;
        if (code_queue.size() == 0) begin
          want = '0;
          note_mismatch("Unexpected result", want, got);
        end else begin
          want = code_queue.pop_front();
          codes_checked++;
          if (got.clamped) clamps_seen++;
          if (got.chars[0] !== want.chars[0] || got.chars[1] !== want.chars[1] ||
              got.chars[2] !== want.chars[2] || got.chars[3] !== want.chars[3] ||
              got.clamped !== want.clamped) begin
            note_mismatch("Mismatch", want, got);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        code_queue.push_back(encode_position(make_item(func_i, coord_i, south_or_west_i)));
        items_sent++;
        in_taken = 1'b1;
      end
    end
  end

  // Driver: a new item (or an idle cycle) only once the current one is gone,
  // so a stalled item keeps its payload and valid.
  always @(negedge clk_i) begin
    pos_item_t it;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        func_i          <= it.func;
        coord_i         <= it.coord;
        south_or_west_i <= it.sow;
        in_valid_i      <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Sink stall, independent of the input side
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: reports failure and stops if the run never finishes
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items: origin, poles, antimeridian, one step past each limit,
    // minutes at 59.9999 and 99.9999, the all-ones coord and bit patterns
    pending_items.push_back(make_item(FuncLat, 28'd0, 1'b0));
    pending_items.push_back(make_item(FuncLat, 28'd0, 1'b1));
    pending_items.push_back(make_item(FuncLat, 28'd90000000, 1'b0));
    pending_items.push_back(make_item(FuncLat, 28'd90000000, 1'b1));
    pending_items.push_back(make_item(FuncLat, 28'd90000060, 1'b0));
    pending_items.push_back(make_item(FuncLat, 28'd90000060, 1'b1));
    pending_items.push_back(make_item(FuncLat, 28'd45599999, 1'b0));
    pending_items.push_back(make_item(FuncLat, 28'd45999999, 1'b1));
    pending_items.push_back(make_item(FuncLon, 28'd0, 1'b0));
    pending_items.push_back(make_item(FuncLon, 28'd0, 1'b1));
    pending_items.push_back(make_item(FuncLon, 28'd180000000, 1'b0));
    pending_items.push_back(make_item(FuncLon, 28'd180000000, 1'b1));
    pending_items.push_back(make_item(FuncLon, 28'd180000060, 1'b0));
    pending_items.push_back(make_item(FuncLon, 28'd180000060, 1'b1));
    pending_items.push_back(make_item(FuncLon, 28'd179599999, 1'b1));
    pending_items.push_back(make_item(FuncLon, 28'd12999999, 1'b0));
    pending_items.push_back(make_item(FuncLat, 28'hFFFFFFF, 1'b0));
    pending_items.push_back(make_item(FuncLat, 28'hFFFFFFF, 1'b1));
    pending_items.push_back(make_item(FuncLon, 28'hFFFFFFF, 1'b0));
    pending_items.push_back(make_item(FuncLon, 28'hFFFFFFF, 1'b1));
    pending_items.push_back(make_item(FuncLat, 28'h5555555, 1'b1));
    pending_items.push_back(make_item(FuncLon, 28'hAAAAAAA, 1'b0));

    // Three idle profiles: sender light / sink heavy, swapped, then none
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 71 : 0;
      stall_pct     = (phase == 0) ? 71 : (phase == 1) ? 13 : 0;
      for (int n = 0; n < RandPerPhase; n++) pending_items.push_back(random_item());
      while (pending_items.size() > 0 || in_valid_i || code_queue.size() > 0)
        @(posedge clk_i);
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (code_queue.size() > 0) begin
      mismatches++;
      $display("%0d expected results never arrived", code_queue.size());
    end

    $display("Encoded %0d coordinates under three handshake profiles; %0d results checked,",
             items_sent, codes_checked);
    $display("%0d of them clamped, %0d errors", clamps_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
